>>> sv/tracker_pattern_unpacker_macros.svh
// assertion macros used by the checker file tpu_checker.sv
`ifndef TRACKER_PATTERN_UNPACKER_MACROS_SVH
`define TRACKER_PATTERN_UNPACKER_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define TPU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define TPU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/tpu_pkg.sv
`default_nettype none

package tpu_pkg;

   localparam int CHANNELS = 64;
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [7:0] NOTE_LIMIT_RESET = 8'd120;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_ROW   = 1'b1;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_EVENT = 2'd1;
   localparam logic [1:0] OP_ROW   = 2'd2;

   // one unit of work handed from the parser to the event stage
   typedef struct packed {
      logic            clr;
      logic [1:0]      op;
      logic [CH_W-1:0] ch;
      logic [7:0]      mask;
      logic [7:0]      note;
      logic [7:0]      instr;
      logic [7:0]      volpan;
      logic [7:0]      cmd;
      logic [7:0]      param;
      logic [6:0]      used;
   } tpu_entry_type;

endpackage

`default_nettype wire

>>> sv/tpu_if.sv
`default_nettype none

interface tpu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_pattern;
   logic       new_module;

   modport source (output valid, data_byte, new_pattern, new_module, input ready);
   modport sink (input valid, data_byte, new_pattern, new_module, output ready);
endinterface

interface tpu_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [6:0] channel;
   logic [7:0] note;
   logic [7:0] instrument;
   logic [7:0] volume_pan;
   logic [7:0] command;
   logic [7:0] command_data;
   logic [6:0] channels_used;

   modport source (output valid, kind, channel, note, instrument, volume_pan, command,
                   command_data, channels_used, input ready);
   modport sink (input valid, kind, channel, note, instrument, volume_pan, command,
                 command_data, channels_used, output ready);
endinterface

interface tpu_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] note_limit;

   modport source (output valid, note_limit, input ready);
   modport sink (input valid, note_limit, output ready);
endinterface

`default_nettype wire

>>> sv/tpu_front.sv
`default_nettype none

module tpu_front import tpu_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   tpu_req_if.sink       req_bus,
   tpu_csr_if.sink       csr_bus,
   input  wire           q_full,
   output logic          push_vld,
   output tpu_entry_type push_ent
);

   localparam logic [2:0] PH_CHAN   = 3'd0;
   localparam logic [2:0] PH_MASK   = 3'd1;
   localparam logic [2:0] PH_NOTE   = 3'd2;
   localparam logic [2:0] PH_INSTR  = 3'd3;
   localparam logic [2:0] PH_VOLPAN = 3'd4;
   localparam logic [2:0] PH_CMD    = 3'd5;
   localparam logic [2:0] PH_PARAM  = 3'd6;
   localparam logic [2:0] PH_LOOK   = 3'd7;

   logic [2:0]      phase_ff, phase_in, phase_eff, nxt;
   logic [CH_W-1:0] chan_ff, chan_in;
   logic [7:0]      mask_ff, mask_in;
   logic [7:0]      note_ff, note_in;
   logic [7:0]      instr_ff, instr_in;
   logic [7:0]      volpan_ff, volpan_in;
   logic [7:0]      cmd_ff, cmd_in;
   logic [6:0]      max_ff, max_in;
   logic [7:0]      limit_ff;

   logic [7:0]          mask_mem [CHANNELS];
   logic [CHANNELS-1:0] mask_vld_ff;
   logic [7:0]          mask_rd_ff;
   logic                mask_rdv_ff;

   logic [7:0] look_mask;
   logic [7:0] b;
   logic [5:0] chan_raw;
   logic       stall, acc, clr, rd_en, mw_en;
   logic [1:0] push_op;

   // first pull phase at or after mask bit 'from'; channel phase when none is left
   function automatic logic [2:0] pull_phase(input logic [3:0] m, input logic [1:0] from);
      logic [2:0] ph;
      ph = PH_CHAN;
      for (int i = 3; i >= 0; i--) begin
         if (m[i] && (i >= int'(from))) begin
            ph = PH_NOTE + 3'(i);
         end
      end
      return ph;
   endfunction

   function automatic logic [6:0] bump(input logic [6:0] mx, input logic [CH_W-1:0] ch);
      return (mx <= 7'(ch)) ? 7'(ch) + 7'd1 : mx;
   endfunction

   assign b        = req_bus.data_byte;
   assign chan_raw = 6'(b - 8'd1);
   assign csr_bus.ready = 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      chan_in   = chan_ff;
      mask_in   = mask_ff;
      note_in   = note_ff;
      instr_in  = instr_ff;
      volpan_in = volpan_ff;
      cmd_in    = cmd_ff;
      max_in    = max_ff;
      push_vld  = 1'b0;
      push_op   = OP_NONE;
      clr       = 1'b0;
      rd_en     = 1'b0;
      mw_en     = 1'b0;
      stall     = 1'b0;
      nxt       = PH_CHAN;
      phase_eff = PH_CHAN;
      look_mask = mask_rdv_ff ? mask_rd_ff : 8'd0;

      // the remembered mask arrived from memory: settle the pending channel byte
      if (phase_ff == PH_LOOK) begin
         if (look_mask == 8'd0) begin
            phase_in = PH_CHAN;
         end else if (look_mask[3:0] == 4'd0) begin
            // reuse-only event takes this cycle on its own
            stall = 1'b1;
            if (!q_full) begin
               mask_in  = look_mask;
               max_in   = bump(max_ff, chan_ff);
               push_vld = 1'b1;
               push_op  = OP_EVENT;
               phase_in = PH_CHAN;
            end
         end else begin
            mask_in  = look_mask;
            max_in   = bump(max_ff, chan_ff);
            phase_in = pull_phase(look_mask[3:0], 2'd0);
         end
      end

      req_bus.ready = !q_full && !stall;
      acc = req_bus.valid && req_bus.ready;

      if (acc) begin
         if (req_bus.new_pattern || req_bus.new_module) begin
            clr      = 1'b1;
            phase_in = PH_CHAN;
            chan_in  = '0;
            mask_in  = 8'd0;
            if (req_bus.new_module) begin
               max_in = 7'd0;
            end
         end
         phase_eff = phase_in;
         case (phase_eff)
            PH_CHAN: begin
               if (b == 8'd0) begin
                  push_vld = 1'b1;
                  push_op  = OP_ROW;
                  phase_in = PH_CHAN;
               end else begin
                  chan_in = CH_W'(chan_raw % CHANNELS);
                  if (b[7]) begin
                     phase_in = PH_MASK;
                  end else begin
                     phase_in = PH_LOOK;
                     rd_en    = 1'b1;
                  end
               end
            end
            PH_MASK: begin
               mask_in = b;
               mw_en   = 1'b1;
               if (b == 8'd0) begin
                  phase_in = PH_CHAN;
               end else begin
                  max_in   = bump(max_in, chan_in);
                  nxt      = pull_phase(b[3:0], 2'd0);
                  phase_in = nxt;
                  if (nxt == PH_CHAN) begin
                     push_vld = 1'b1;
                     push_op  = OP_EVENT;
                  end
               end
            end
            PH_NOTE: begin
               note_in  = (b <= limit_ff) ? b + 8'd1 : b;
               nxt      = pull_phase(mask_in[3:0], 2'd1);
               phase_in = nxt;
               if (nxt == PH_CHAN) begin
                  push_vld = 1'b1;
                  push_op  = OP_EVENT;
               end
            end
            PH_INSTR: begin
               instr_in = b;
               nxt      = pull_phase(mask_in[3:0], 2'd2);
               phase_in = nxt;
               if (nxt == PH_CHAN) begin
                  push_vld = 1'b1;
                  push_op  = OP_EVENT;
               end
            end
            PH_VOLPAN: begin
               volpan_in = b + 8'd1;
               nxt       = pull_phase(mask_in[3:0], 2'd3);
               phase_in  = nxt;
               if (nxt == PH_CHAN) begin
                  push_vld = 1'b1;
                  push_op  = OP_EVENT;
               end
            end
            PH_CMD: begin
               cmd_in   = b;
               phase_in = PH_PARAM;
            end
            PH_PARAM: begin
               push_vld = 1'b1;
               push_op  = OP_EVENT;
               phase_in = PH_CHAN;
            end
            default: begin
               phase_in = PH_CHAN;
            end
         endcase
         // a clear must reach the event stage even when the byte yields nothing
         if (clr) begin
            push_vld = 1'b1;
         end
      end
   end

   always_comb begin
      push_ent.clr    = clr;
      push_ent.op     = push_op;
      push_ent.ch     = chan_in;
      push_ent.mask   = mask_in;
      push_ent.note   = note_in;
      push_ent.instr  = instr_in;
      push_ent.volpan = volpan_in;
      push_ent.cmd    = cmd_in;
      push_ent.param  = b;
      push_ent.used   = max_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CHAN;
         chan_ff     <= '0;
         mask_ff     <= 8'd0;
         max_ff      <= 7'd0;
         limit_ff    <= NOTE_LIMIT_RESET;
         mask_vld_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         chan_ff  <= chan_in;
         mask_ff  <= mask_in;
         max_ff   <= max_in;
         if (csr_bus.valid) begin
            limit_ff <= csr_bus.note_limit;
         end
         if (clr) begin
            mask_vld_ff <= '0;
         end
         if (mw_en) begin
            mask_vld_ff[chan_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      note_ff   <= note_in;
      instr_ff  <= instr_in;
      volpan_ff <= volpan_in;
      cmd_ff    <= cmd_in;
      if (mw_en) begin
         mask_mem[chan_ff] <= b;
      end
      if (rd_en) begin
         mask_rd_ff  <= mask_mem[chan_in];
         mask_rdv_ff <= !clr && mask_vld_ff[chan_in];
      end
   end

endmodule

`default_nettype wire

>>> sv/tpu_queue.sv
`default_nettype none

module tpu_queue import tpu_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire           push_vld,
   input  tpu_entry_type push_ent,
   output logic          q_full,
   input  wire           pop,
   output logic          head_vld,
   output tpu_entry_type head_ent
);

   tpu_entry_type     slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign q_full   = (cnt_ff == (QPTR_W + 1)'(QDEPTH));
   assign head_vld = (cnt_ff != '0);
   assign head_ent = slot_ff[rd_ptr_ff];
   assign do_push  = push_vld && !q_full;
   assign do_pop   = pop && head_vld;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_ent;
      end
   end

endmodule

`default_nettype wire

>>> sv/tpu_back.sv
`default_nettype none

module tpu_back import tpu_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire           head_vld,
   input  tpu_entry_type head_ent,
   output logic          pop,
   tpu_rsp_if.source     rsp_bus
);

   logic [7:0]  note_mem   [CHANNELS];
   logic [7:0]  instr_mem  [CHANNELS];
   logic [7:0]  volpan_mem [CHANNELS];
   logic [15:0] cmd_mem    [CHANNELS];

   logic [CHANNELS-1:0] note_vld_ff, instr_vld_ff, volpan_vld_ff, cmd_vld_ff;

   // read stage
   logic          b_vld_ff, b_vld_in;
   tpu_entry_type b_ent_ff;
   logic [7:0]    note_rd_ff, instr_rd_ff, volpan_rd_ff;
   logic [15:0]   cmd_rd_ff;
   logic          note_rdv_ff, instr_rdv_ff, volpan_rdv_ff, cmd_rdv_ff;

   // result register
   logic       out_vld_ff, out_vld_in;
   logic       kind_ff;
   logic [6:0] channel_ff;
   logic [7:0] note_ff, instr_ff, volpan_ff, cmd_ff, param_ff;
   logic [6:0] used_ff;

   logic out_free, b_free, is_event;
   logic wr_note, wr_instr, wr_volpan, wr_cmd;
   logic [15:0] cmd_sel;

   // fresh byte if pulled, remembered one if reused, else zero
   function automatic logic [15:0] pick(input logic pulled, input logic reused,
                                        input logic [15:0] fresh, input logic rdv,
                                        input logic [15:0] rd);
      logic [15:0] v;
      v = 16'd0;
      if (pulled) begin
         v = fresh;
      end else if (reused && rdv) begin
         v = rd;
      end
      return v;
   endfunction

   assign out_free = !out_vld_ff || rsp_bus.ready;
   assign b_free   = !b_vld_ff || out_free;
   assign pop      = head_vld && b_free;

   assign wr_note   = pop && (head_ent.op == OP_EVENT) && head_ent.mask[0];
   assign wr_instr  = pop && (head_ent.op == OP_EVENT) && head_ent.mask[1];
   assign wr_volpan = pop && (head_ent.op == OP_EVENT) && head_ent.mask[2];
   assign wr_cmd    = pop && (head_ent.op == OP_EVENT) && head_ent.mask[3];

   assign is_event = (b_ent_ff.op == OP_EVENT);
   assign cmd_sel  = pick(b_ent_ff.mask[3], b_ent_ff.mask[7],
                          {b_ent_ff.cmd, b_ent_ff.param}, cmd_rdv_ff, cmd_rd_ff);

   always_comb begin
      b_vld_in = b_vld_ff;
      if (pop) begin
         b_vld_in = (head_ent.op != OP_NONE);
      end else if (out_free) begin
         b_vld_in = 1'b0;
      end
      out_vld_in = out_free ? b_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff      <= 1'b0;
         out_vld_ff    <= 1'b0;
         note_vld_ff   <= '0;
         instr_vld_ff  <= '0;
         volpan_vld_ff <= '0;
         cmd_vld_ff    <= '0;
      end else begin
         b_vld_ff   <= b_vld_in;
         out_vld_ff <= out_vld_in;
         // clear applies before the entry's own writes
         if (pop && head_ent.clr) begin
            note_vld_ff   <= '0;
            instr_vld_ff  <= '0;
            volpan_vld_ff <= '0;
            cmd_vld_ff    <= '0;
         end
         if (wr_note) begin
            note_vld_ff[head_ent.ch] <= 1'b1;
         end
         if (wr_instr) begin
            instr_vld_ff[head_ent.ch] <= 1'b1;
         end
         if (wr_volpan) begin
            volpan_vld_ff[head_ent.ch] <= 1'b1;
         end
         if (wr_cmd) begin
            cmd_vld_ff[head_ent.ch] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_note) begin
         note_mem[head_ent.ch] <= head_ent.note;
      end
      if (wr_instr) begin
         instr_mem[head_ent.ch] <= head_ent.instr;
      end
      if (wr_volpan) begin
         volpan_mem[head_ent.ch] <= head_ent.volpan;
      end
      if (wr_cmd) begin
         cmd_mem[head_ent.ch] <= {head_ent.cmd, head_ent.param};
      end
      if (pop) begin
         b_ent_ff      <= head_ent;
         note_rd_ff    <= note_mem[head_ent.ch];
         instr_rd_ff   <= instr_mem[head_ent.ch];
         volpan_rd_ff  <= volpan_mem[head_ent.ch];
         cmd_rd_ff     <= cmd_mem[head_ent.ch];
         note_rdv_ff   <= !head_ent.clr && note_vld_ff[head_ent.ch];
         instr_rdv_ff  <= !head_ent.clr && instr_vld_ff[head_ent.ch];
         volpan_rdv_ff <= !head_ent.clr && volpan_vld_ff[head_ent.ch];
         cmd_rdv_ff    <= !head_ent.clr && cmd_vld_ff[head_ent.ch];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && b_vld_ff) begin
         used_ff <= b_ent_ff.used;
         if (is_event) begin
            kind_ff    <= KIND_EVENT;
            channel_ff <= 7'(b_ent_ff.ch) + 7'd1;
            note_ff    <= 8'(pick(b_ent_ff.mask[0], b_ent_ff.mask[4], 16'(b_ent_ff.note),
                                  note_rdv_ff, 16'(note_rd_ff)));
            instr_ff   <= 8'(pick(b_ent_ff.mask[1], b_ent_ff.mask[5], 16'(b_ent_ff.instr),
                                  instr_rdv_ff, 16'(instr_rd_ff)));
            volpan_ff  <= 8'(pick(b_ent_ff.mask[2], b_ent_ff.mask[6],
                                  16'(b_ent_ff.volpan), volpan_rdv_ff,
                                  16'(volpan_rd_ff)));
            cmd_ff     <= cmd_sel[15:8];
            param_ff   <= cmd_sel[7:0];
         end else begin
            kind_ff    <= KIND_ROW;
            channel_ff <= 7'd0;
            note_ff    <= 8'd0;
            instr_ff   <= 8'd0;
            volpan_ff  <= 8'd0;
            cmd_ff     <= 8'd0;
            param_ff   <= 8'd0;
         end
      end
   end

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.kind          = kind_ff;
   assign rsp_bus.channel       = channel_ff;
   assign rsp_bus.note          = note_ff;
   assign rsp_bus.instrument    = instr_ff;
   assign rsp_bus.volume_pan    = volpan_ff;
   assign rsp_bus.command       = cmd_ff;
   assign rsp_bus.command_data  = param_ff;
   assign rsp_bus.channels_used = used_ff;

endmodule

`default_nettype wire

>>> sv/tracker_pattern_unpacker.sv
`default_nettype none

// Packed tracker pattern unpacker. Takes one stream byte per clock on the request
// channel while the queue has room, and returns one event record per finished
// channel entry, or a row-end record for a zero channel byte. The one exception
// to one byte per clock is a channel byte without a mask byte whose remembered
// mask pulls no further bytes: the mask memory read is registered, and the event
// is emitted in a cycle of its own, in which the request channel is not ready. A
// parser accepts and classifies bytes, a four-entry queue follows, and an event
// stage owns the per-channel value memories (one write and one registered read
// per cycle); a result passes through the queue, the read stage and the result
// register before it is offered on the response channel, also behind the mask read
// in the reuse-only case above, and waits in the queue while the receiver holds off.
// The per-channel memories are cleared at once by reset or a new_pattern or
// new_module request through valid bits, so there is no clearing pass. note_limit
// resets to 120 and is written through the csr port, which is always ready.
module tracker_pattern_unpacker import tpu_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   tpu_req_if.sink    req_bus,
   tpu_rsp_if.source  rsp_bus,
   tpu_csr_if.sink    csr_bus
);

   logic          push_vld, q_full, head_vld, pop;
   tpu_entry_type push_ent, head_ent;

   tpu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr_bus  (csr_bus),
      .q_full   (q_full),
      .push_vld (push_vld),
      .push_ent (push_ent)
   );

   tpu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_vld (push_vld),
      .push_ent (push_ent),
      .q_full   (q_full),
      .pop      (pop),
      .head_vld (head_vld),
      .head_ent (head_ent)
   );

   tpu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_vld (head_vld),
      .head_ent (head_ent),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

>>> sv/tpu_checker.sv
`default_nettype none

`include "tracker_pattern_unpacker_macros.svh"

module tpu_checker import tpu_pkg::*; (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_kind,
   input wire [6:0] rsp_channel,
   input wire [7:0] rsp_note,
   input wire [7:0] rsp_instrument,
   input wire [7:0] rsp_volume_pan,
   input wire [7:0] rsp_command,
   input wire [7:0] rsp_command_data,
   input wire [6:0] rsp_channels_used
);

   // a waiting result holds until taken
   `TPU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_channel) && $stable(rsp_note) && $stable(rsp_instrument) && $stable(rsp_volume_pan) && $stable(rsp_command) && $stable(rsp_command_data) && $stable(rsp_channels_used), "result changed while stalled")

   // the channel count is raised before its event leaves
   `TPU_ASSERT_NOW(a_event_chan, rsp_valid && (rsp_kind == KIND_EVENT), (rsp_channel != 7'd0) && (rsp_channel <= rsp_channels_used), "event channel outside channels_used")

   // nothing comes out right after reset
   `TPU_ASSERT_NOW(a_reset_quiet, $past(reset), !rsp_valid, "result right after reset")

endmodule

bind tracker_pattern_unpacker tpu_checker u_tpu_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_kind          (rsp_bus.kind),
   .rsp_channel       (rsp_bus.channel),
   .rsp_note          (rsp_bus.note),
   .rsp_instrument    (rsp_bus.instrument),
   .rsp_volume_pan    (rsp_bus.volume_pan),
   .rsp_command       (rsp_bus.command),
   .rsp_command_data  (rsp_bus.command_data),
   .rsp_channels_used (rsp_bus.channels_used)
);

`default_nettype wire

>>> sim/tpu_event_checker.sv
`timescale 1ns / 1ps

module tpu_event_checker import tpu_pkg::*; (
   input  wire  clock,
   input  wire  reset,
   tpu_req_if   req_mon,
   tpu_rsp_if   rsp_mon,
   tpu_csr_if   csr_mon,
   output int   mismatches,
   output int   outstanding
);

   typedef enum logic [2:0] {
      WAIT_CHAN, WAIT_MASK, GET_NOTE, GET_INSTR, GET_VOLPAN, GET_CMD, GET_PARAM, DO_EMIT
   } parse_state_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] channel;
      logic [7:0] note;
      logic [7:0] instrument;
      logic [7:0] volume_pan;
      logic [7:0] command;
      logic [7:0] command_data;
      logic [6:0] channels_used;
   } event_rec_type;

   logic [7:0]      limit_reg;
   parse_state_type parse_state;
   logic [CH_W-1:0] cur_ch;
   logic [7:0]      cur_mask;
   logic [7:0]      mask_mem   [CHANNELS];
   logic [7:0]      note_mem   [CHANNELS];
   logic [7:0]      instr_mem  [CHANNELS];
   logic [7:0]      volpan_mem [CHANNELS];
   logic [7:0]      cmd_mem    [CHANNELS];
   logic [7:0]      param_mem  [CHANNELS];
   logic [6:0]      max_ch;

   event_rec_type expected_events [$];

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   function automatic void clear_pattern();
      for (int i = 0; i < CHANNELS; i++) begin
         mask_mem[i] = '0;
         note_mem[i] = '0;
         instr_mem[i] = '0;
         volpan_mem[i] = '0;
         cmd_mem[i] = '0;
         param_mem[i] = '0;
      end
      parse_state = WAIT_CHAN;
      cur_ch = '0;
      cur_mask = '0;
   endfunction

   // first field still to pull at or above mask bit 'from'
   function automatic parse_state_type next_pull(input logic [7:0] mask, input int from);
      for (int i = from; i < 4; i++) begin
         if (mask[i]) return parse_state_type'(int'(GET_NOTE) + i);
      end
      return DO_EMIT;
   endfunction

   function automatic bit finish_entry(output event_rec_type r);
      r = '0;
      r.kind = KIND_EVENT;
      r.channel = 7'(cur_ch) + 7'd1;
      r.note = (cur_mask & 8'h11) != 0 ? note_mem[cur_ch] : 8'd0;
      r.instrument = (cur_mask & 8'h22) != 0 ? instr_mem[cur_ch] : 8'd0;
      r.volume_pan = (cur_mask & 8'h44) != 0 ? volpan_mem[cur_ch] : 8'd0;
      r.command = (cur_mask & 8'h88) != 0 ? cmd_mem[cur_ch] : 8'd0;
      r.command_data = (cur_mask & 8'h88) != 0 ? param_mem[cur_ch] : 8'd0;
      r.channels_used = max_ch;
      parse_state = WAIT_CHAN;
      return 1'b1;
   endfunction

   function automatic bit pull_from(input int from, output event_rec_type r);
      r = '0;
      parse_state = next_pull(cur_mask, from);
      if (parse_state == DO_EMIT) return finish_entry(r);
      return 1'b0;
   endfunction

   // mask is known: a zero mask drops the entry
   function automatic bit open_entry(output event_rec_type r);
      r = '0;
      if (cur_mask == 8'd0) begin
         parse_state = WAIT_CHAN;
         return 1'b0;
      end
      if (max_ch <= 7'(cur_ch)) max_ch = 7'(cur_ch) + 7'd1;
      return pull_from(0, r);
   endfunction

   function automatic bit unpack_byte(input logic [7:0] b, input logic np, input logic nm,
                                      output event_rec_type r);
      logic [CH_W-1:0] ch;
      ch = cur_ch;
      r = '0;
      if (np || nm) clear_pattern();
      if (nm) max_ch = '0;
      case (parse_state)
         WAIT_MASK: begin
            cur_mask = b;
            mask_mem[ch] = b;
            return open_entry(r);
         end
         GET_NOTE: begin
            note_mem[ch] = (b <= limit_reg) ? b + 8'd1 : b;
            return pull_from(1, r);
         end
         GET_INSTR: begin
            instr_mem[ch] = b;
            return pull_from(2, r);
         end
         GET_VOLPAN: begin
            volpan_mem[ch] = b + 8'd1;
            return pull_from(3, r);
         end
         GET_CMD: begin
            cmd_mem[ch] = b;
            parse_state = GET_PARAM;
            return 1'b0;
         end
         GET_PARAM: begin
            param_mem[ch] = b;
            return finish_entry(r);
         end
         default: ;
      endcase
      if (b == 8'd0) begin
         r.kind = KIND_ROW;
         r.channels_used = max_ch;
         parse_state = WAIT_CHAN;
         return 1'b1;
      end
      cur_ch = CH_W'(((b - 8'd1) & 8'd63) % CHANNELS);
      if (b[7]) begin
         parse_state = WAIT_MASK;
         return 1'b0;
      end
      cur_mask = mask_mem[cur_ch];
      return open_entry(r);
   endfunction

   function automatic string show(input event_rec_type r);
      return $sformatf("kind=%0d ch=%0d note=%h ins=%h vp=%h cmd=%h dat=%h used=%0d",
                       r.kind, r.channel, r.note, r.instrument, r.volume_pan, r.command,
                       r.command_data, r.channels_used);
   endfunction

   function automatic void note_failure(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
   endfunction

   always @(posedge clock) begin : monitor
      event_rec_type want;
      event_rec_type got;
      if (reset) begin
         limit_reg = NOTE_LIMIT_RESET;
         clear_pattern();
         max_ch = '0;
         expected_events.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) limit_reg = csr_mon.note_limit;
         if (req_mon.valid && req_mon.ready) begin
            if (unpack_byte(req_mon.data_byte, req_mon.new_pattern, req_mon.new_module, want))
               expected_events.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.kind, rsp_mon.channel, rsp_mon.note, rsp_mon.instrument,
                   rsp_mon.volume_pan, rsp_mon.command, rsp_mon.command_data,
                   rsp_mon.channels_used};
            if (expected_events.size() == 0) begin
               note_failure({"result with nothing expected: ", show(got)});
            end else begin
               want = expected_events.pop_front();
               if (got !== want)
                  note_failure({"result mismatch: expected ", show(want), " got ", show(got)});
            end
         end
      end
      outstanding = expected_events.size();
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tpu_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_BYTES    = 85;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpu_req_if req_if();
   tpu_rsp_if rsp_if();
   tpu_csr_if csr_if();

   int n_bad;
   int n_pending;
   int bytes_sent = 0;
   int idle_cycles = 0;

   bit no_gaps = 1'b0;
   bit rsp_eager = 1'b0;
   bit hold_rsp = 1'b0;
   bit restart_next = 1'b0;
   logic [7:0] cur_limit = NOTE_LIMIT_RESET;
   logic [7:0] chan_masks_sent [64];

   always #4 clock = ~clock;

   tracker_pattern_unpacker DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   tpu_event_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_mon     (csr_if),
      .mismatches  (n_bad),
      .outstanding (n_pending)
   );

   function automatic int req_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic np, input logic nm);
      int gap;
      gap = req_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.new_pattern <= np;
      req_if.new_module <= nm;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic write_limit(input logic [7:0] v);
      csr_if.valid <= 1'b1;
      csr_if.note_limit <= v;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      cur_limit = v;
   endtask

   // let every pending result out, then give zero-mask entries time to finish
   task automatic settle();
      req_if.valid <= 1'b0;
      while (n_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_mask();
      int r;
      r = $urandom_range(99);
      if (r < 12) return 8'h00;
      if (r < 24) return {4'($urandom_range(1, 15)), 4'h0};
      return 8'($urandom_range(0, 255));
   endfunction

   // one pattern entry or row end: mostly well formed, sometimes cut short or plain noise
   task automatic send_entry();
      int r;
      logic np;
      logic nm;
      logic [7:0] cb;
      logic [7:0] mask;
      logic [7:0] val;
      logic [5:0] ch;
      bit with_mask;
      bit cut_short;
      r = $urandom_range(99);
      np = restart_next || ($urandom_range(99) < 3);
      nm = ($urandom_range(99) < 2);
      restart_next = 1'b0;
      if (np || nm) begin
         for (int i = 0; i < 64; i++) chan_masks_sent[i] = 8'h00;
      end
      if (r < 8) begin
         send_byte(8'h00, np, nm);
      end else if (r < 94) begin
         cb = 8'($urandom_range(1, 127));
         ch = 6'(cb - 8'd1);
         with_mask = ($urandom_range(3) != 0);
         cb[7] = with_mask;
         send_byte(cb, np, nm);
         if (with_mask) begin
            mask = pick_mask();
            send_byte(mask, 1'b0, 1'b0);
            chan_masks_sent[ch] = mask;
         end else begin
            mask = chan_masks_sent[ch];
         end
         if (mask == 8'h00) return;
         cut_short = ($urandom_range(99) < 4);
         for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
               if (cut_short && $urandom_range(2) == 0) begin
                  restart_next = 1'b1;
                  return;
               end
               val = 8'($urandom_range(0, 255));
               // notes right at the limit and one above it
               if (i == 0 && $urandom_range(9) < 3) val = cur_limit + 8'($urandom_range(0, 1));
               send_byte(val, 1'b0, 1'b0);
               if (i == 3) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
         end
      end else begin
         send_byte(8'($urandom_range(0, 255)), np, nm);
         restart_next = 1'b1;
      end
   endtask

   initial begin : rsp_side
      int stall;
      int r;
      stall = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            r = $urandom_range(99);
            if (rsp_eager || r < 70) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int target;
      logic [7:0] lim;
      req_if.valid = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.new_pattern = 1'b0;
      req_if.new_module = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.note_limit = 8'h00;
      for (int i = 0; i < 64; i++) chan_masks_sent[i] = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // row end at module start, then a full entry on channel 1
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'h81, 1'b0, 1'b0); send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h78, 1'b0, 1'b0); send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0); send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      // remembered mask, note just above the limit
      send_byte(8'h01, 1'b0, 1'b0); send_byte(8'h79, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0); send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0); send_byte(8'h00, 1'b0, 1'b0);
      // channel 64, reuse-only mask, then the same mask remembered
      send_byte(8'hC0, 1'b0, 1'b0); send_byte(8'hF0, 1'b0, 1'b0);
      send_byte(8'h40, 1'b0, 1'b0);
      // zero mask given and remembered
      send_byte(8'h82, 1'b0, 1'b0); send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h02, 1'b0, 1'b0);
      // folded channel byte, largest note
      send_byte(8'hFF, 1'b0, 1'b0); send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      // entry cut off by a new pattern, then a new module
      send_byte(8'h83, 1'b0, 1'b0); send_byte(8'h0F, 1'b0, 1'b0);
      send_byte(8'h05, 1'b0, 1'b0); send_byte(8'h05, 1'b1, 1'b0);
      send_byte(8'h00, 1'b1, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            settle();
            case (ph)
               1: lim = 8'h00;
               2: lim = 8'hFF;
               4: lim = NOTE_LIMIT_RESET;
               default: lim = 8'($urandom_range(0, 255));
            endcase
            write_limit(lim);
         end
         no_gaps = (ph == 4);
         rsp_eager = (ph == 4);
         if (ph == 3) begin
            // receiver holds off while requests keep coming
            no_gaps = 1'b1;
            hold_rsp = 1'b1;
            repeat (40) send_entry();
            no_gaps = 1'b0;
         end
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) send_entry();
      end
      settle();

      if (n_bad == 0 && n_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> tracker_pattern_unpacker.f
+incdir+sv
sv/tpu_pkg.sv
sv/tpu_if.sv
sv/tpu_front.sv
sv/tpu_queue.sv
sv/tpu_back.sv
sv/tracker_pattern_unpacker.sv
sv/tpu_checker.sv
sim/tpu_event_checker.sv
sim/tb_top.sv
